FILE: src/vfc_pkg.sv
// Shared types, constants and saturation helpers for the view frustum culler.
package vfc_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MEM_DEPTH     = 72;
    localparam int ADDR_W        = 7;
    localparam int PROJ_BASE     = 0;
    localparam int MV_BASE       = 16;
    localparam int CLIP_BASE     = 32;
    localparam int PLANE_BASE    = 48;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_REBUILD = 2'd1;
    localparam logic [1:0] FUNC_BOX     = 2'd2;
    localparam logic [1:0] FUNC_SPHERE  = 2'd3;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic square;
    } mac_in_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31])
            r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

FILE: src/vfc_mem.sv
// State memory: matrices, clip scratch and planes, one write and two registered reads.
module vfc_mem (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vfc_pkg::mem_wr_t                     wr,
    input  logic [vfc_pkg::ADDR_W-1:0]           rd_addr_a,
    input  logic [vfc_pkg::ADDR_W-1:0]           rd_addr_b,
    output logic [vfc_pkg::DATA_W-1:0]           rd_data_a,
    output logic [vfc_pkg::DATA_W-1:0]           rd_data_b
);
    import vfc_pkg::*;

    logic [DATA_W-1:0]    mem [0:MEM_DEPTH-1];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // entries never written read as zero
        rd_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
        rd_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: src/vfc_mac.sv
// Shared multiply-accumulate pipeline: registered product, then fixed-point or square accumulate.
module vfc_mac #(
    parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vfc_pkg::mac_in_t    in,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    output logic                res_valid,
    output logic [63:0]         res
);
    import vfc_pkg::*;

    mac_in_t            tag_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        acc_next;
    logic [63:0]        term;
    logic               res_valid_reg;

    always_comb
    begin
        // floor shift for fixed-point products, raw product for squares
        term     = tag_reg.square ? prod_reg : 64'(prod_reg >>> FRAC_BITS);
        acc_next = tag_reg.first ? term : acc_reg + term;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            tag_reg       <= in;
            res_valid_reg <= tag_reg.valid && tag_reg.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = acc_reg;

endmodule

FILE: src/vfc_isqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
module vfc_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] n,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] n_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

FILE: src/vfc_div.sv
// Restoring divider for plane normalisation: (mag << FRAC_BITS) / len, signed and saturated.
module vfc_div #(
    parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        mag,
    input  logic               neg,
    input  logic [31:0]        len,
    output logic               done,
    output logic signed [31:0] quot
);
    localparam int DW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [DW-1:0] NEG_LIM = DW'(64'h8000_0000);
    localparam logic [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);

    logic [DW-1:0]    dvd_reg;
    logic [DW-1:0]    q_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      len_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [32:0]      rem_sh;
    logic             fits;

    always_comb
    begin
        rem_sh = {rem_reg[31:0], dvd_reg[DW-1]};
        fits   = rem_sh >= {1'b0, len_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {mag, {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            rem_reg <= '0;
            len_reg <= len;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= fits ? rem_sh - {1'b0, len_reg} : rem_sh;
            q_reg   <= {q_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
            quot = (q_reg > NEG_LIM) ? 32'sh8000_0000 : -$signed(q_reg[31:0]);
        else
            quot = (q_reg > POS_LIM) ? 32'sh7FFF_FFFF : $signed(q_reg[31:0]);
    end

    assign done = done_reg;

endmodule

FILE: src/view_frustum_culler_core.sv
// Top level of the view frustum culler: sequencer, state memory and arithmetic units.
//
// One item is handled at a time; s_tready is high only while the sequencer is idle, and a
// finished result waits in the output register without holding up the next transfer. A matrix
// load writes the state memory as its transfer is accepted. Every dot product (clip element,
// plane distance, squared length) runs through the one shared multiply-accumulate pipeline
// fed by the state memory; the squared length has three terms. A sphere test tries one plane
// at a time (at most 6 planes); a box test tries one corner at a time, from 6 up to 48 corner
// products. A rebuild is 16 clip products, then per plane coefficient forming, one squared
// length, a square root and four divisions, or four zeroed coefficients for a zero length.
// Control registers reset asynchronously; unwritten memory entries then read as zero.
module view_frustum_culler_core #(
    parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // elem_index[4:0], elem_value[36:5], pos_x[68:37], pos_y[100:69], pos_z[132:101],
    // min_x[164:133], min_y[196:165], min_z[228:197], max_x[260:229], max_y[292:261],
    // max_z[324:293], zero pad[327:325]
    input  logic [327:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // visible[0], distance[32:1], degenerate[33], zero pad[39:34]
    output logic [39:0]  m_tdata
);
    import vfc_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_ISSUE = 11'b000_0000_0010,
        ST_WAIT  = 11'b000_0000_0100,
        ST_RAW   = 11'b000_0000_1000,
        ST_RAWW  = 11'b000_0001_0000,
        ST_SQRT  = 11'b000_0010_0000,
        ST_ZERO  = 11'b000_0100_0000,
        ST_NRD   = 11'b000_1000_0000,
        ST_NDAT  = 11'b001_0000_0000,
        ST_NDIV  = 11'b010_0000_0000,
        ST_RESP  = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        DOT_CLIP  = 2'd0,
        DOT_PLANE = 2'd1,
        DOT_SQ    = 2'd2
    } dot_t;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    state_t state_reg, state_next;
    dot_t   mode_reg, mode_next;
    logic [1:0]  func_reg, func_next;
    logic [1:0]  term_reg, term_next;
    logic [2:0]  plane_reg, plane_next;
    logic [2:0]  corner_reg, corner_next;
    logic [3:0]  elem_reg, elem_next;
    logic        deg_reg, deg_next;
    logic        vis_reg, vis_next;
    logic [31:0] dist_reg, dist_next;
    logic [31:0] len_reg, len_next;

    logic signed [31:0] val_reg, pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [31:0] min_x_reg, min_y_reg, min_z_reg, max_x_reg, max_y_reg, max_z_reg;

    mac_in_t     iss, tag_reg, mac_in;
    logic [1:0]  tag_term_reg;
    logic        raw_iss, raw_valid_reg;
    logic [1:0]  raw_term_reg;

    mem_wr_t           wr;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [31:0]       rd_data_a, rd_data_b;

    logic        mac_res_valid;
    logic [63:0] mac_res;
    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;
    logic        div_start, div_done;
    logic signed [31:0] div_quot;

    logic        m_tvalid_reg, out_load;
    logic        out_vis_reg, out_deg_reg;
    logic [31:0] out_dist_reg;

    logic signed [31:0] cx, cy, cz, opb, dot_d;
    logic signed [32:0] sph_sum;
    logic [1:0]  last_term;
    logic [1:0]  col;
    logic        plus;
    logic [ADDR_W-1:0] plane_addr;
    logic signed [31:0] raw_val;

    assign s_tready = (state_reg == ST_IDLE);

    // corner coordinates for a box test, the centre for a sphere test
    always_comb
    begin
        if (func_reg == FUNC_BOX)
        begin
            cx = sat33(33'(pos_x_reg) + 33'(corner_reg[0] ? max_x_reg : min_x_reg));
            cy = sat33(33'(pos_y_reg) + 33'(corner_reg[1] ? max_y_reg : min_y_reg));
            cz = sat33(33'(pos_z_reg) + 33'(corner_reg[2] ? max_z_reg : min_z_reg));
        end
        else
        begin
            cx = pos_x_reg;
            cy = pos_y_reg;
            cz = pos_z_reg;
        end
    end

    always_comb
    begin
        case (mode_reg)
            DOT_CLIP: opb = rd_data_b;
            DOT_SQ:   opb = rd_data_a;
            default:
            begin
                case (tag_term_reg)
                    2'd0:    opb = cx;
                    2'd1:    opb = cy;
                    2'd2:    opb = cz;
                    default: opb = ONE;
                endcase
            end
        endcase
        mac_in        = tag_reg;
        mac_in.square = (mode_reg == DOT_SQ);
    end

    always_comb
    begin
        col        = plane_reg[2:1];
        plus       = (plane_reg == 3'd1) || (plane_reg == 3'd2) || (plane_reg == 3'd5);
        plane_addr = ADDR_W'(PLANE_BASE) + ADDR_W'({plane_reg, term_reg});
        last_term  = (mode_reg == DOT_SQ) ? 2'd2 : 2'd3;
        dot_d      = sat64(mac_res);
        sph_sum    = 33'(dot_d) + 33'(val_reg);
        raw_val    = sat33(plus ? 33'($signed(rd_data_a)) + 33'($signed(rd_data_b))
                                : 33'($signed(rd_data_a)) - 33'($signed(rd_data_b)));
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        func_next   = func_reg;
        term_next   = term_reg;
        plane_next  = plane_reg;
        corner_next = corner_reg;
        elem_next   = elem_reg;
        deg_next    = deg_reg;
        vis_next    = vis_reg;
        dist_next   = dist_reg;
        len_next    = len_reg;
        iss         = '0;
        raw_iss     = 1'b0;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        wr          = '0;
        // coefficient forming writes in the cycle after its reads are issued
        if (raw_valid_reg)
        begin
            wr.en   = 1'b1;
            wr.addr = ADDR_W'(PLANE_BASE) + ADDR_W'({plane_reg, raw_term_reg});
            wr.data = raw_val;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = s_tuser;
                    term_next   = '0;
                    plane_next  = '0;
                    corner_next = '0;
                    elem_next   = '0;
                    deg_next    = 1'b0;
                    vis_next    = 1'b0;
                    dist_next   = '0;
                    case (s_tuser)
                        FUNC_LOAD:
                        begin
                            wr.en      = 1'b1;
                            wr.addr    = ADDR_W'(s_tdata[4:0]);
                            wr.data    = s_tdata[36:5];
                            state_next = ST_RESP;
                        end
                        FUNC_REBUILD:
                        begin
                            mode_next  = DOT_CLIP;
                            state_next = ST_ISSUE;
                        end
                        default:
                        begin
                            mode_next  = DOT_PLANE;
                            state_next = ST_ISSUE;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                if (mode_reg == DOT_CLIP)
                begin
                    rd_addr_a = ADDR_W'(MV_BASE) + ADDR_W'({elem_reg[3:2], term_reg});
                    rd_addr_b = ADDR_W'(PROJ_BASE) + ADDR_W'({term_reg, elem_reg[1:0]});
                end
                else
                begin
                    rd_addr_a = plane_addr;
                end
                iss.valid = 1'b1;
                iss.first = (term_reg == 2'd0);
                iss.last  = (term_reg == last_term);
                if (term_reg == last_term)
                begin
                    term_next  = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    term_next = term_reg + 2'd1;
                end
            end
            ST_WAIT:
            begin
                if (mac_res_valid)
                begin
                    case (mode_reg)
                        DOT_CLIP:
                        begin
                            wr.en   = 1'b1;
                            wr.addr = ADDR_W'(CLIP_BASE) + ADDR_W'(elem_reg);
                            wr.data = dot_d;
                            if (elem_reg == 4'd15)
                            begin
                                plane_next = '0;
                                state_next = ST_RAW;
                            end
                            else
                            begin
                                elem_next  = elem_reg + 4'd1;
                                state_next = ST_ISSUE;
                            end
                        end
                        DOT_SQ:
                        begin
                            sqrt_start = 1'b1;
                            state_next = ST_SQRT;
                        end
                        default:
                        begin
                            if (func_reg == FUNC_BOX)
                            begin
                                if (dot_d > 32'sd0)
                                begin
                                    if (plane_reg == 3'd5)
                                    begin
                                        vis_next   = 1'b1;
                                        dist_next  = dot_d;
                                        state_next = ST_RESP;
                                    end
                                    else
                                    begin
                                        plane_next  = plane_reg + 3'd1;
                                        corner_next = '0;
                                        state_next  = ST_ISSUE;
                                    end
                                end
                                else if (corner_reg == 3'd7)
                                begin
                                    state_next = ST_RESP;
                                end
                                else
                                begin
                                    corner_next = corner_reg + 3'd1;
                                    state_next  = ST_ISSUE;
                                end
                            end
                            else
                            begin
                                if (sph_sum <= 33'sd0)
                                begin
                                    state_next = ST_RESP;
                                end
                                else if (plane_reg == 3'd5)
                                begin
                                    vis_next   = 1'b1;
                                    dist_next  = sat33(sph_sum);
                                    state_next = ST_RESP;
                                end
                                else
                                begin
                                    plane_next = plane_reg + 3'd1;
                                    state_next = ST_ISSUE;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_RAW:
            begin
                rd_addr_a = ADDR_W'(CLIP_BASE) + ADDR_W'({term_reg, 2'd3});
                rd_addr_b = ADDR_W'(CLIP_BASE) + ADDR_W'({term_reg, col});
                raw_iss   = 1'b1;
                term_next = term_reg + 2'd1;
                if (term_reg == 2'd3)
                begin
                    state_next = ST_RAWW;
                end
            end
            ST_RAWW:
            begin
                mode_next  = DOT_SQ;
                term_next  = '0;
                state_next = ST_ISSUE;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    len_next  = sqrt_root;
                    term_next = '0;
                    if (sqrt_root == '0)
                    begin
                        deg_next   = 1'b1;
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        state_next = ST_NRD;
                    end
                end
            end
            ST_ZERO:
            begin
                wr.en     = 1'b1;
                wr.addr   = plane_addr;
                wr.data   = '0;
                term_next = term_reg + 2'd1;
                if (term_reg == 2'd3)
                begin
                    if (plane_reg == 3'd5)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        plane_next = plane_reg + 3'd1;
                        state_next = ST_RAW;
                    end
                end
            end
            ST_NRD:
            begin
                rd_addr_a  = plane_addr;
                state_next = ST_NDAT;
            end
            ST_NDAT:
            begin
                div_start  = 1'b1;
                state_next = ST_NDIV;
            end
            ST_NDIV:
            begin
                if (div_done)
                begin
                    wr.en     = 1'b1;
                    wr.addr   = plane_addr;
                    wr.data   = div_quot;
                    term_next = term_reg + 2'd1;
                    if (term_reg != 2'd3)
                    begin
                        state_next = ST_NRD;
                    end
                    else if (plane_reg == 3'd5)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        plane_next = plane_reg + 3'd1;
                        state_next = ST_RAW;
                    end
                end
            end
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= DOT_CLIP;
            func_reg      <= FUNC_LOAD;
            term_reg      <= '0;
            plane_reg     <= '0;
            corner_reg    <= '0;
            elem_reg      <= '0;
            deg_reg       <= 1'b0;
            vis_reg       <= 1'b0;
            dist_reg      <= '0;
            len_reg       <= '0;
            tag_reg       <= '0;
            tag_term_reg  <= '0;
            raw_valid_reg <= 1'b0;
            raw_term_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            func_reg      <= func_next;
            term_reg      <= term_next;
            plane_reg     <= plane_next;
            corner_reg    <= corner_next;
            elem_reg      <= elem_next;
            deg_reg       <= deg_next;
            vis_reg       <= vis_next;
            dist_reg      <= dist_next;
            len_reg       <= len_next;
            tag_reg       <= iss;
            tag_term_reg  <= term_reg;
            raw_valid_reg <= raw_iss;
            raw_term_reg  <= term_reg;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // hold the payload of the accepted transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            val_reg   <= s_tdata[36:5];
            pos_x_reg <= s_tdata[68:37];
            pos_y_reg <= s_tdata[100:69];
            pos_z_reg <= s_tdata[132:101];
            min_x_reg <= s_tdata[164:133];
            min_y_reg <= s_tdata[196:165];
            min_z_reg <= s_tdata[228:197];
            max_x_reg <= s_tdata[260:229];
            max_y_reg <= s_tdata[292:261];
            max_z_reg <= s_tdata[324:293];
        end
        if (out_load)
        begin
            out_vis_reg  <= vis_reg;
            out_dist_reg <= dist_reg;
            out_deg_reg  <= deg_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_deg_reg, out_dist_reg, out_vis_reg};

    vfc_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    vfc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (mac_in),
        .a         ($signed(rd_data_a)),
        .b         (opb),
        .res_valid (mac_res_valid),
        .res       (mac_res)
    );

    vfc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .n     (mac_res),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    vfc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (rd_data_a[31] ? 32'(-rd_data_a) : rd_data_a),
        .neg   (rd_data_a[31]),
        .len   (len_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

endmodule

FILE: src/vfc_checker.sv
// Port-level checks on the culler, bound to the top level.
module vfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    // one item at a time: no second transfer straight after the first
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("distance not zero on a culled or non-test result");

    a_deg_not_visible: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> !m_tdata[0])
        else $error("degenerate and visible together");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind view_frustum_culler_core vfc_checker u_vfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/view_frustum_culler_core_test.sv
// Self-checking testbench for the view frustum culler core: scene loads, rebuilds, box and sphere tests.
module view_frustum_culler_core_test;
    import vfc_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic [4:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] pos[3];
        logic signed [31:0] lo[3];
        logic signed [31:0] hi[3];
    } cull_item_t;

    typedef struct {
        logic               vis;
        logic signed [31:0] dval;
        logic               deg;
    } cull_res_t;

    class cull_scoreboard;
        logic signed [31:0] proj[16];
        logic signed [31:0] mv[16];
        logic signed [31:0] plane[24];
        cull_res_t          pending[$];
        int                 errors;
        int                 checked;
        int                 n_visible;
        int                 n_degen;

        function new();
            foreach (proj[i]) proj[i] = '0;
            foreach (mv[i]) mv[i] = '0;
            foreach (plane[i]) plane[i] = '0;
            errors = 0;
            checked = 0;
            n_visible = 0;
            n_degen = 0;
        endfunction

        function longint sat(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC_BITS_DEF;
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > n) bt = bt >> 2;
            while (bt != 0)
            begin
                if (n >= res + bt)
                begin
                    n = n - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                    res = res >> 1;
                bt = bt >> 2;
            end
            return res;
        endfunction

        function longint ndiv(longint raw, longint unsigned len);
            longint unsigned mag;
            longint unsigned q;
            mag = (raw < 0) ? longint'(-raw) : longint'(raw);
            q = (mag << FRAC_BITS_DEF) / len;
            if (raw < 0)
            begin
                if (q > 64'h8000_0000) return -64'sd2147483648;
                return -longint'(q);
            end
            if (q > 64'h7FFF_FFFF) return 64'sd2147483647;
            return longint'(q);
        endfunction

        function bit rebuild_planes();
            int             cols[6];
            int             sgn[6];
            longint         clip[16];
            longint         raw[4];
            longint         acc;
            longint unsigned sq;
            longint unsigned len;
            bit             degen;
            cols = '{0, 0, 1, 1, 2, 2};
            sgn = '{-1, 1, 1, -1, -1, 1};
            degen = 0;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += fmul(mv[r*4+k], proj[k*4+c]);
                    clip[r*4+c] = sat(acc);
                end
            for (int p = 0; p < 6; p++)
            begin
                sq = 0;
                for (int k = 0; k < 4; k++)
                    raw[k] = sat(sgn[p] > 0 ? clip[k*4+3] + clip[k*4+cols[p]]
                                            : clip[k*4+3] - clip[k*4+cols[p]]);
                for (int k = 0; k < 3; k++) sq += longint'(raw[k] * raw[k]);
                len = isqrt(sq);
                for (int k = 0; k < 4; k++)
                    plane[p*4+k] = (len == 0) ? 32'sd0 : 32'(ndiv(raw[k], len));
                if (len == 0) degen = 1;
            end
            return degen;
        endfunction

        function longint plane_dist(int p, longint x, longint y, longint z);
            return sat(fmul(plane[p*4], x) + fmul(plane[p*4+1], y) + fmul(plane[p*4+2], z)
                       + longint'(plane[p*4+3]));
        endfunction

        function void note(cull_item_t it);
            cull_res_t r;
            longint    d;
            longint    x, y, z;
            longint    v;
            bit        culled;
            bit        passed;
            r.vis = 0;
            r.dval = '0;
            r.deg = 0;
            v = it.val;
            case (it.func)
                FUNC_LOAD:
                begin
                    if (it.idx < 16) proj[it.idx] = it.val;
                    else mv[it.idx - 16] = it.val;
                end
                FUNC_REBUILD:
                    r.deg = rebuild_planes();
                FUNC_BOX:
                begin
                    d = 0;
                    culled = 0;
                    for (int p = 0; p < 6 && !culled; p++)
                    begin
                        passed = 0;
                        // corner order: x fastest, then y, then z
                        for (int i = 0; i < 8 && !passed; i++)
                        begin
                            x = sat(longint'(it.pos[0]) + (i[0] ? it.hi[0] : it.lo[0]));
                            y = sat(longint'(it.pos[1]) + (i[1] ? it.hi[1] : it.lo[1]));
                            z = sat(longint'(it.pos[2]) + (i[2] ? it.hi[2] : it.lo[2]));
                            d = plane_dist(p, x, y, z);
                            if (d > 0) passed = 1;
                        end
                        if (!passed) culled = 1;
                    end
                    if (!culled)
                    begin
                        r.vis = 1;
                        r.dval = 32'(d);
                    end
                end
                default:
                begin
                    d = 0;
                    culled = 0;
                    for (int p = 0; p < 6 && !culled; p++)
                    begin
                        d = plane_dist(p, it.pos[0], it.pos[1], it.pos[2]);
                        if (d <= -v) culled = 1;
                    end
                    if (!culled)
                    begin
                        r.vis = 1;
                        r.dval = 32'(sat(d + v));
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check(logic [39:0] word);
            cull_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                fail($sformatf("result %h with nothing outstanding", word));
                return;
            end
            e = pending.pop_front();
            if (word[0] !== e.vis)
                fail($sformatf("visible exp %0d got %0d", e.vis, word[0]));
            if (word[32:1] !== e.dval)
                fail($sformatf("distance exp %h got %h", e.dval, word[32:1]));
            if (word[33] !== e.deg)
                fail($sformatf("degenerate exp %0d got %0d", e.deg, word[33]));
            if (word[39:34] !== 6'd0)
                fail($sformatf("pad bits set: %h", word[39:34]));
            if (e.vis) n_visible++;
            if (e.deg) n_degen++;
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [327:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    cull_scoreboard sb;
    int send_idle;
    int recv_idle;
    int n_sent;
    int stall_left;
    int quiet;
    bit stall_req;

    view_frustum_culler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (stall_req)
        begin
            stall_req = 0;
            stall_left = 400;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check(m_tdata);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= 20000)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input cull_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {3'b0, it.hi[2], it.hi[1], it.hi[0], it.lo[2], it.lo[1], it.lo[0],
                     it.pos[2], it.pos[1], it.pos[0], it.val, it.idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note(it);
        n_sent++;
    endtask

    function automatic cull_item_t blank(logic [1:0] f);
        cull_item_t it;
        it.func = f;
        it.idx = '0;
        it.val = '0;
        for (int i = 0; i < 3; i++)
        begin
            it.pos[i] = '0;
            it.lo[i] = '0;
            it.hi[i] = '0;
        end
        return it;
    endfunction

    function automatic cull_item_t noise_item();
        cull_item_t it;
        it.func = 2'($urandom_range(3));
        if (it.func == FUNC_REBUILD && $urandom_range(9) != 0) it.func = FUNC_BOX;
        it.idx = 5'($urandom);
        it.val = $urandom;
        for (int i = 0; i < 3; i++)
        begin
            it.pos[i] = $urandom;
            it.lo[i] = $urandom;
            it.hi[i] = $urandom;
        end
        return it;
    endfunction

    task automatic load(input int idx, input logic signed [31:0] v);
        cull_item_t it;
        it = blank(FUNC_LOAD);
        it.idx = 5'(idx);
        it.val = v;
        send(it);
    endtask

    // load both matrices in random order, then rebuild the planes
    task automatic load_scene();
        int order[32];
        int j, t;
        bit wild;
        logic signed [31:0] v;
        wild = ($urandom_range(7) == 0);
        foreach (order[i]) order[i] = i;
        for (int i = 31; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i])
        begin
            if (wild)
                v = $urandom;
            else if (order[i][1:0] == order[i][3:2])
                v = $urandom_range(131072, 32768);
            else
                v = $signed($urandom_range(40000)) - 20000;
            if ($urandom_range(1)) v = -v;
            load(order[i], v);
        end
        send(blank(FUNC_REBUILD));
    endtask

    task automatic volume_test();
        cull_item_t it;
        it = blank($urandom_range(1) ? FUNC_BOX : FUNC_SPHERE);
        it.idx = 5'($urandom);
        it.val = $urandom_range(196608);
        if ($urandom_range(9) == 0) it.val = -it.val;
        for (int i = 0; i < 3; i++)
        begin
            it.pos[i] = $signed($urandom_range(1048576)) - 524288;
            it.lo[i] = -$signed($urandom_range(131072));
            it.hi[i] = $urandom_range(131072);
        end
        send(it);
    endtask

    initial
    begin
        cull_item_t it;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        stall_req = 0;
        stall_left = 0;
        quiet = 0;
        n_sent = 0;
        send_idle = 0;
        recv_idle = 0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero planes: box culled, sphere visible for a positive radius only
        send(blank(FUNC_BOX));
        it = blank(FUNC_SPHERE);
        it.val = 32'sd5;
        send(it);
        it.val = -32'sd1;
        send(it);
        it.val = 32'sh8000_0000;
        send(it);
        it.val = 32'sh7FFF_FFFF;
        send(it);
        send(blank(FUNC_REBUILD));
        load(0, 32'sh8000_0000);
        load(31, 32'sh7FFF_FFFF);
        send(blank(FUNC_REBUILD));
        // identity modelview and projection
        for (int i = 0; i < 4; i++)
        begin
            load(i*5, 32'sh0001_0000);
            load(16 + i*5, 32'sh0001_0000);
        end
        send(blank(FUNC_REBUILD));
        it = blank(FUNC_BOX);
        for (int i = 0; i < 3; i++)
        begin
            it.pos[i] = 32'sh7FFF_FFFF;
            it.hi[i] = 32'sh7FFF_FFFF;
            it.lo[i] = 32'sh8000_0000;
        end
        send(it);
        for (int i = 0; i < 3; i++) it.pos[i] = 32'sh8000_0000;
        send(it);
        it.func = FUNC_SPHERE;
        it.val = 32'sh7FFF_FFFF;
        send(it);
        it = blank(FUNC_SPHERE);
        it.val = 32'sh0000_8000;
        send(it);
        // saturating matrices
        for (int i = 0; i < 32; i += 3) load(i, 32'sh7FFF_FFFF);
        send(blank(FUNC_REBUILD));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 23 : (phase == 1) ? 88 : 0;
            recv_idle = (phase == 0) ? 88 : (phase == 1) ? 23 : 0;
            for (int s = 0; s < 6; s++)
            begin
                if (phase == 2 && s == 2) stall_req = 1;
                load_scene();
                for (int n = 0; n < 55; n++)
                    if ($urandom_range(9) == 0) send(noise_item());
                    else volume_test();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d items and %0d results: %0d visible, %0d degenerate rebuilds",
                 n_sent, sb.checked, sb.n_visible, sb.n_degen);
        $display("three back-pressure phases and one long output hold-off; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
